[hdl/agbr_pkg.sv]
// Package for the adjoint graph check and rebuild unit.
// Types, codes and constants shared by the controller, datapath and top level.
`timescale 1ns / 1ps
package agbr_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int VCNT_W           = 6;
  localparam int IDX_W            = 5;
  localparam int LBL_W            = 7;
  localparam int LABEL_SLOTS      = 65;
  localparam int S_DATA_W         = 16;
  localparam int M_DATA_W         = 32;
  localparam logic [VCNT_W-1:0] VCNT_RESET = 6'd32;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_ARC   = 2'd1,
    REQ_EVAL  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    VERDICT_NONE = 2'd0,
    VERDICT_ADJ  = 2'd1,
    VERDICT_LINE = 2'd2
  } verdict_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ARC_RD,
    ST_ARC_WR,
    ST_ADJ_RDA,
    ST_ADJ_LATA,
    ST_ADJ_SCAN,
    ST_ADJ_DONE,
    ST_LBL_RD,
    ST_LBL_UPD,
    ST_CNT,
    ST_EMIT,
    ST_EMIT_FAIL
  } state_e;

  typedef struct packed {
    logic clear_graph;
    logic arc_latch;
    logic use_arc;
    logic rd_en;
    logic arc_write;
    logic eval_init;
    logic latch_a;
    logic cmp_en;
    logic lbl_upd;
    logic cnt_en;
    logic cnt_side;
    logic out_load;
    logic out_fail;
    logic out_last;
  } cmd_t;

  typedef struct packed {
    logic arc_ok;
    logic eval_ok;
    logic out_free;
  } stat_t;

endpackage

[hdl/adjoint_graph_check_and_rebuild_unit.sv]
// Adjoint graph check and rebuild unit, top level. Clear and unused codes are handled in idle;
// arc load reads the rows, then writes if the arc is in range. Evaluate: row-pair scan, decision,
// labelling, counting, then N words at one per cycle when the sink is ready.
// A new word is taken while the previous result word waits. Reset is asynchronous, active
// low: empty graph, flag clear, vertex_count 32; no clearing pass is needed.
`timescale 1ns / 1ps
module adjoint_graph_check_and_rebuild_unit #(
  parameter int MAX_VERTICES = agbr_pkg::MAX_VERTICES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [agbr_pkg::VCNT_W-1:0]       cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [agbr_pkg::S_DATA_W-1:0]     s_axis_tdata,  // arc_source, arc_target
  input  logic [1:0]                        s_axis_tuser,  // req_type
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // original_vertex_count, arc_index, arc_tail, arc_head
  output logic [agbr_pkg::M_DATA_W-1:0]     m_axis_tdata,
  output logic [1:0]                        m_axis_tuser,  // verdict
  output logic                              m_axis_tlast
);
  import agbr_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);

  cmd_t             cmd;
  stat_t            stat;
  logic [IW-1:0]    addr;
  logic [IW:0]      n;
  logic [LBL_W-1:0] count, tail, head;
  logic [IDX_W-1:0] index;

  agbr_ctrl #(.MAX_VERTICES(MAX_VERTICES)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_req_i   (s_axis_tuser),
    .in_ready_o (s_axis_tready),
    .n_i        (n),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .addr_o     (addr)
  );

  agbr_dpath #(.MAX_VERTICES(MAX_VERTICES)) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_src_i      (s_axis_tdata[4:0]),
    .in_dst_i      (s_axis_tdata[9:5]),
    .cmd_i         (cmd),
    .addr_i        (addr),
    .stat_o        (stat),
    .n_o           (n),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_verdict_o (m_axis_tuser),
    .out_count_o   (count),
    .out_index_o   (index),
    .out_tail_o    (tail),
    .out_head_o    (head),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {6'd0, head, tail, index, count};

  // a failed check gives one all-zero last word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == VERDICT_NONE) |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("failed verdict word is not a lone zero word");

  // no new request while an evaluation is still streaming words
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input taken during result stream");

  // every vertex of an adjoint graph carries both labels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != VERDICT_NONE) |->
      (m_axis_tdata[18:12] != '0) && (m_axis_tdata[25:19] != '0))
    else $error("unlabelled arc in adjoint result");

endmodule

[hdl/agbr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module agbr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/agbr_ctrl.sv]
// Sequencer for the adjoint graph check and rebuild unit.
// Depends on agbr_pkg; drives the datapath through cmd_t, reads stat_t.
`timescale 1ns / 1ps
module agbr_ctrl #(
  parameter int MAX_VERTICES = agbr_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [1:0]                    in_req_i,
  output logic                          in_ready_o,
  input  logic [$clog2(MAX_VERTICES):0] n_i,
  input  agbr_pkg::stat_t               stat_i,
  output agbr_pkg::cmd_t                cmd_o,
  output logic [$clog2(MAX_VERTICES)-1:0] addr_o
);
  import agbr_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);

  state_e         state_q, state_d;
  logic [IW-1:0]  a_q, a_d, b_q, b_d;
  logic           side_q, side_d;
  logic [IW-1:0]  nm1;
  logic           accept;

  assign nm1    = IW'(n_i - 1'b1);
  assign accept = in_valid_i && (state_q == ST_IDLE);

  // next state and counters
  always_comb begin
    state_d = state_q;
    a_d     = a_q;
    b_d     = b_q;
    side_d  = side_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          case (in_req_i)
            REQ_ARC: state_d = ST_ARC_RD;
            REQ_EVAL: begin
              a_d     = '0;
              state_d = (nm1 == '0) ? ST_ADJ_DONE : ST_ADJ_RDA;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ARC_RD:   state_d = stat_i.arc_ok ? ST_ARC_WR : ST_IDLE;
      ST_ARC_WR:   state_d = ST_IDLE;
      ST_ADJ_RDA:  state_d = ST_ADJ_LATA;
      ST_ADJ_LATA: begin
        b_d     = a_q + 1'b1;
        state_d = ST_ADJ_SCAN;
      end
      ST_ADJ_SCAN: begin
        if (b_q == nm1) begin
          if (a_q + 1'b1 == nm1) begin
            state_d = ST_ADJ_DONE;
          end else begin
            a_d     = a_q + 1'b1;
            state_d = ST_ADJ_RDA;
          end
        end else begin
          b_d = b_q + 1'b1;
        end
      end
      ST_ADJ_DONE: begin
        a_d     = '0;
        state_d = stat_i.eval_ok ? ST_LBL_RD : ST_EMIT_FAIL;
      end
      ST_LBL_RD:  state_d = ST_LBL_UPD;
      ST_LBL_UPD: begin
        if (a_q == nm1) begin
          a_d     = '0;
          side_d  = 1'b0;
          state_d = ST_CNT;
        end else begin
          a_d     = a_q + 1'b1;
          state_d = ST_LBL_RD;
        end
      end
      ST_CNT: begin
        side_d = ~side_q;
        if (side_q) begin
          if (a_q == nm1) begin
            a_d     = '0;
            state_d = ST_EMIT;
          end else begin
            a_d = a_q + 1'b1;
          end
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          if (a_q == nm1) begin
            state_d = ST_IDLE;
          end else begin
            a_d = a_q + 1'b1;
          end
        end
      end
      ST_EMIT_FAIL: begin
        if (stat_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o  = '0;
    addr_o = a_q;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.arc_latch   = accept;
        cmd_o.clear_graph = accept && (in_req_i == REQ_CLEAR);
        cmd_o.eval_init   = accept && (in_req_i == REQ_EVAL);
      end
      ST_ARC_RD: begin
        cmd_o.use_arc = 1'b1;
        cmd_o.rd_en   = stat_i.arc_ok;
      end
      ST_ARC_WR: begin
        cmd_o.use_arc   = 1'b1;
        cmd_o.arc_write = 1'b1;
      end
      ST_ADJ_RDA:  cmd_o.rd_en = 1'b1;
      ST_ADJ_LATA: begin
        cmd_o.latch_a = 1'b1;
        cmd_o.rd_en   = 1'b1;
        addr_o        = a_q + 1'b1;
      end
      ST_ADJ_SCAN: begin
        // data on the read port belongs to row b_q
        cmd_o.cmp_en = 1'b1;
        cmd_o.rd_en  = (b_q != nm1);
        addr_o       = b_q + 1'b1;
      end
      ST_ADJ_DONE: ;
      ST_LBL_RD:   cmd_o.rd_en   = 1'b1;
      ST_LBL_UPD:  cmd_o.lbl_upd = 1'b1;
      ST_CNT: begin
        cmd_o.cnt_en   = 1'b1;
        cmd_o.cnt_side = side_q;
      end
      ST_EMIT: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_last = (a_q == nm1);
      end
      ST_EMIT_FAIL: begin
        cmd_o.out_load = stat_i.out_free;
        cmd_o.out_fail = 1'b1;
        cmd_o.out_last = 1'b1;
      end
      default: ;
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      a_q     <= '0;
      b_q     <= '0;
      side_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      b_q     <= b_d;
      side_q  <= side_d;
    end
  end

endmodule

[hdl/agbr_dpath.sv]
// Datapath: adjacency row and column RAMs, pair compare, labels, label count,
// output word register. Depends on agbr_pkg and agbr_ram.
`timescale 1ns / 1ps
module agbr_dpath #(
  parameter int MAX_VERTICES = agbr_pkg::MAX_VERTICES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [agbr_pkg::VCNT_W-1:0]     cfg_wdata_i,
  input  logic [agbr_pkg::IDX_W-1:0]      in_src_i,
  input  logic [agbr_pkg::IDX_W-1:0]      in_dst_i,
  input  agbr_pkg::cmd_t                  cmd_i,
  input  logic [$clog2(MAX_VERTICES)-1:0] addr_i,
  output agbr_pkg::stat_t                 stat_o,
  output logic [$clog2(MAX_VERTICES):0]   n_o,
  input  logic                            out_ready_i,
  output logic                            out_valid_o,
  output logic [1:0]                      out_verdict_o,
  output logic [agbr_pkg::LBL_W-1:0]      out_count_o,
  output logic [agbr_pkg::IDX_W-1:0]      out_index_o,
  output logic [agbr_pkg::LBL_W-1:0]      out_tail_o,
  output logic [agbr_pkg::LBL_W-1:0]      out_head_o,
  output logic                            out_last_o
);
  import agbr_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int NW = IW + 1;
  localparam int SW = $clog2(LABEL_SLOTS);

  logic [VCNT_W-1:0]       vcnt_q;
  logic [VCNT_W-1:0]       n_clamp;
  logic [NW-1:0]           n;
  logic [MAX_VERTICES-1:0] nmask;

  logic [IDX_W-1:0]        src_q, dst_q;
  logic [IW-1:0]           src_idx, dst_idx;

  logic [MAX_VERTICES-1:0] row_vld_q, col_vld_q;
  logic                    row_rvld_q, col_rvld_q;
  logic [MAX_VERTICES-1:0] row_raw, col_raw, row_rd, col_rd;
  logic [IW-1:0]           row_raddr, col_raddr;
  logic                    arc_dup, do_write;
  logic [MAX_VERTICES-1:0] row_wdata, col_wdata;

  logic                    multi_q, adj_ok_q, line_ok_q;
  logic [MAX_VERTICES-1:0] ra_q, ca_q;
  logic                    share_succ;

  logic [LBL_W-1:0]        tail_q [MAX_VERTICES];
  logic [LBL_W-1:0]        head_q [MAX_VERTICES];
  logic [LBL_W-1:0]        next_q;
  logic [LBL_W-1:0]        lt, lh, t_new, h_new, h_fin, next1, next2;

  logic [LABEL_SLOTS-1:0]  seen_q;
  logic [LBL_W-1:0]        count_q;
  logic [LBL_W-1:0]        cnt_v;
  logic [SW-1:0]           cnt_slot;
  logic                    cnt_hit;

  logic                    out_valid_q;

  // effective vertex count
  always_comb begin
    if (vcnt_q == '0) begin
      n_clamp = VCNT_W'(1);
    end else if (vcnt_q > VCNT_W'(MAX_VERTICES)) begin
      n_clamp = VCNT_W'(MAX_VERTICES);
    end else begin
      n_clamp = vcnt_q;
    end
  end
  assign n   = NW'(n_clamp);
  assign n_o = n;

  always_comb begin
    for (int i = 0; i < MAX_VERTICES; i++) begin
      nmask[i] = (VCNT_W'(i) < n_clamp);
    end
  end

  assign src_idx = src_q[IW-1:0];
  assign dst_idx = dst_q[IW-1:0];

  assign stat_o.arc_ok   = (VCNT_W'(src_q) < n_clamp) && (VCNT_W'(dst_q) < n_clamp);
  assign stat_o.eval_ok  = !multi_q && adj_ok_q;
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  // adjacency: rows hold successors, columns hold predecessors
  assign row_raddr = cmd_i.use_arc ? src_idx : addr_i;
  assign col_raddr = cmd_i.use_arc ? dst_idx : addr_i;
  assign row_rd    = row_raw & {MAX_VERTICES{row_rvld_q}};
  assign col_rd    = col_raw & {MAX_VERTICES{col_rvld_q}};
  assign arc_dup   = row_rd[dst_idx];
  assign do_write  = cmd_i.arc_write && !arc_dup;
  assign row_wdata = row_rd | (MAX_VERTICES'(1) << dst_idx);
  assign col_wdata = col_rd | (MAX_VERTICES'(1) << src_idx);

  agbr_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (src_idx),
    .wdata_i (row_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (row_raddr),
    .rdata_o (row_raw)
  );

  agbr_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (dst_idx),
    .wdata_i (col_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (col_raddr),
    .rdata_o (col_raw)
  );

  assign share_succ = |(ra_q & row_rd & nmask);

  // labelling step for vertex addr_i
  assign lt    = tail_q[addr_i];
  assign lh    = head_q[addr_i];
  assign t_new = (lt == '0) ? next_q : lt;
  assign next1 = (lt == '0) ? next_q + 1'b1 : next_q;
  assign h_new = (lh == '0) ? next1 : lh;
  assign next2 = (lh == '0) ? next1 + 1'b1 : next1;
  // a self loop ties the head to the tail before successors are touched
  assign h_fin = col_rd[addr_i] ? t_new : h_new;

  assign cnt_v    = cmd_i.cnt_side ? head_q[addr_i] : tail_q[addr_i];
  assign cnt_slot = SW'(cnt_v);
  assign cnt_hit  = (cnt_v != '0) && (cnt_v < LBL_W'(LABEL_SLOTS)) && !seen_q[cnt_slot];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcnt_q      <= VCNT_RESET;
      row_vld_q   <= '0;
      col_vld_q   <= '0;
      row_rvld_q  <= 1'b0;
      col_rvld_q  <= 1'b0;
      multi_q     <= 1'b0;
      adj_ok_q    <= 1'b1;
      line_ok_q   <= 1'b1;
      next_q      <= LBL_W'(1);
      seen_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) begin
        tail_q[i] <= '0;
        head_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) vcnt_q <= cfg_wdata_i;
      if (cmd_i.rd_en) begin
        row_rvld_q <= row_vld_q[row_raddr];
        col_rvld_q <= col_vld_q[col_raddr];
      end
      if (cmd_i.clear_graph) begin
        row_vld_q <= '0;
        col_vld_q <= '0;
        multi_q   <= 1'b0;
      end
      if (cmd_i.arc_write) begin
        if (arc_dup) begin
          multi_q <= 1'b1;
        end else begin
          row_vld_q[src_idx] <= 1'b1;
          col_vld_q[dst_idx] <= 1'b1;
        end
      end
      if (cmd_i.eval_init) begin
        adj_ok_q  <= 1'b1;
        line_ok_q <= 1'b1;
        next_q    <= LBL_W'(1);
        seen_q    <= '0;
        count_q   <= '0;
        for (int i = 0; i < MAX_VERTICES; i++) begin
          tail_q[i] <= '0;
          head_q[i] <= '0;
        end
      end
      if (cmd_i.cmp_en && share_succ) begin
        if (|((ra_q ^ row_rd) & nmask)) adj_ok_q <= 1'b0;
        if (|(ca_q & col_rd & nmask))   line_ok_q <= 1'b0;
      end
      if (cmd_i.lbl_upd) begin
        next_q <= next2;
        for (int i = 0; i < MAX_VERTICES; i++) begin
          if (col_rd[i] && nmask[i]) begin
            head_q[i] <= t_new;
          end else if (IW'(i) == addr_i) begin
            head_q[i] <= h_new;
          end
          if (row_rd[i] && nmask[i]) begin
            tail_q[i] <= h_fin;
          end else if (IW'(i) == addr_i) begin
            tail_q[i] <= t_new;
          end
        end
      end
      if (cmd_i.cnt_en && cnt_hit) begin
        seen_q[cnt_slot] <= 1'b1;
        count_q          <= count_q + 1'b1;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_a) begin
      ra_q <= row_rd & nmask;
      ca_q <= col_rd & nmask;
    end
    if (cmd_i.arc_latch) begin
      src_q <= in_src_i;
      dst_q <= in_dst_i;
    end
    if (cmd_i.out_load) begin
      out_last_o <= cmd_i.out_last;
      if (cmd_i.out_fail) begin
        out_verdict_o <= VERDICT_NONE;
        out_count_o   <= '0;
        out_index_o   <= '0;
        out_tail_o    <= '0;
        out_head_o    <= '0;
      end else begin
        out_verdict_o <= line_ok_q ? VERDICT_LINE : VERDICT_ADJ;
        out_count_o   <= count_q;
        out_index_o   <= IDX_W'(addr_i);
        out_tail_o    <= tail_q[addr_i];
        out_head_o    <= head_q[addr_i];
      end
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[sim/adjoint_graph_check_and_rebuild_unit_tb.sv]
// Testbench for the adjoint graph check and rebuild unit.
// Drives clear/arc/evaluate words, predicts result words with its own graph model
// and checks them; depends on agbr_pkg and the top level only.
`timescale 1ns / 1ps
module adjoint_graph_check_and_rebuild_unit_tb;
  import agbr_pkg::*;

  typedef struct packed {
    logic [1:0] verdict;
    logic [6:0] orig_cnt;
    logic [4:0] idx;
    logic [6:0] tail;
    logic [6:0] head;
    logic       last;
  } arc_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [VCNT_W-1:0] cfg_wdata_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic m_axis_tlast;

  adjoint_graph_check_and_rebuild_unit dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // graph model
  logic [31:0] adj_rows [32];
  logic        multi_flag;
  logic [5:0]  vcnt_reg;
  arc_word_t   expected_words [$];

  int send_idle_pct, recv_idle_pct;
  int hold_off_cycles;
  int errors, idle_cycles, evals_seen;

  function automatic int used_vertices();
    int n;
    n = vcnt_reg;
    if (n < 1) n = 1;
    if (n > 32) n = 32;
    return n;
  endfunction

  task automatic predict_word(input logic [1:0] req, input logic [4:0] src,
                              input logic [4:0] dst);
    int n, nxt, cnt;
    logic [31:0] m;
    logic is_adj, is_line;
    logic [6:0] tl [32];
    logic [6:0] hd [32];
    bit seen [65];
    arc_word_t w;
    n = used_vertices();
    m = (n >= 32) ? 32'hFFFF_FFFF : ((32'd1 << n) - 1);
    case (req)
      REQ_CLEAR: begin
        foreach (adj_rows[i]) adj_rows[i] = '0;
        multi_flag = 1'b0;
      end
      REQ_ARC: begin
        if (src < n && dst < n) begin
          if (adj_rows[src][dst]) multi_flag = 1'b1;
          else adj_rows[src][dst] = 1'b1;
        end
      end
      REQ_EVAL: begin
        is_adj = !multi_flag;
        for (int a = 0; a + 1 < n; a++)
          for (int b = a + 1; b < n; b++)
            if ((adj_rows[a] & adj_rows[b] & m) != 0 && ((adj_rows[a] ^ adj_rows[b]) & m) != 0)
              is_adj = 1'b0;
        if (!is_adj) begin
          w = '0;
          w.last = 1'b1;
          expected_words.push_back(w);
        end else begin
          is_line = 1'b1;
          for (int a = 0; a + 1 < n; a++)
            for (int b = a + 1; b < n; b++)
              if ((adj_rows[a] & adj_rows[b] & m) != 0)
                for (int d = 0; d < n; d++)
                  if (adj_rows[d][a] && adj_rows[d][b]) is_line = 1'b0;
          foreach (tl[i]) begin
            tl[i] = '0;
            hd[i] = '0;
          end
          nxt = 1;
          for (int a = 0; a < n; a++) begin
            if (tl[a] == 0) begin tl[a] = 7'(nxt); nxt++; end
            if (hd[a] == 0) begin hd[a] = 7'(nxt); nxt++; end
            for (int c = 0; c < n; c++) if (adj_rows[c][a]) hd[c] = tl[a];
            for (int b = 0; b < n; b++) if (adj_rows[a][b]) tl[b] = hd[a];
          end
          cnt = 0;
          for (int a = 0; a < n; a++) begin
            if (tl[a] != 0 && !seen[tl[a]]) begin seen[tl[a]] = 1; cnt++; end
            if (hd[a] != 0 && !seen[hd[a]]) begin seen[hd[a]] = 1; cnt++; end
          end
          for (int a = 0; a < n; a++) begin
            w.verdict = is_line ? VERDICT_LINE : VERDICT_ADJ;
            w.orig_cnt = 7'(cnt);
            w.idx = 5'(a);
            w.tail = tl[a];
            w.head = hd[a];
            w.last = (a == n - 1);
            expected_words.push_back(w);
          end
        end
      end
      default: ;
    endcase
  endtask

  // valid stays up after acceptance until the next word or stop_sending at that negedge
  task automatic send_word(input logic [1:0] req, input logic [4:0] src, input logic [4:0] dst);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= req;
    s_axis_tdata <= {6'd0, dst, src};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predict_word(req, src, dst);
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic drain_and_config(input logic [5:0] val);
    stop_sending();
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (700) @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    vcnt_reg = val;
  endtask

  // receiver and checker
  always @(posedge clk_i) begin
    arc_word_t got, exp_w;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.verdict = m_axis_tuser;
      got.orig_cnt = m_axis_tdata[6:0];
      got.idx = m_axis_tdata[11:7];
      got.tail = m_axis_tdata[18:12];
      got.head = m_axis_tdata[25:19];
      got.last = m_axis_tlast;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
      end else begin
        exp_w = expected_words.pop_front();
        if (got.last) evals_seen++;
        if (got.verdict !== exp_w.verdict)
          $display("%0t: verdict expected %0d actual %0d", $time, exp_w.verdict, got.verdict);
        if (got.orig_cnt !== exp_w.orig_cnt)
          $display("%0t: vertex count expected %0d actual %0d", $time, exp_w.orig_cnt,
                   got.orig_cnt);
        if (got.idx !== exp_w.idx)
          $display("%0t: arc index expected %0d actual %0d", $time, exp_w.idx, got.idx);
        if (got.tail !== exp_w.tail)
          $display("%0t: tail expected %0d actual %0d", $time, exp_w.tail, got.tail);
        if (got.head !== exp_w.head)
          $display("%0t: head expected %0d actual %0d", $time, exp_w.head, got.head);
        if (got.last !== exp_w.last)
          $display("%0t: last expected %0d actual %0d", $time, exp_w.last, got.last);
        if (got !== exp_w) errors++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog: cycles with no accepted word
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > 20000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_directed();
    drain_and_config(6'd4);
    send_word(REQ_EVAL, 0, 0);                       // empty graph, adjoint
    send_word(REQ_ARC, 0, 1);
    send_word(REQ_ARC, 1, 2);
    send_word(REQ_ARC, 2, 3);
    send_word(REQ_ARC, 3, 0);
    send_word(REQ_ARC, 31, 0);                       // out of range, ignored
    send_word(REQ_ARC, 0, 31);
    send_word(2'd3, 5'h1F, 5'h1F);                   // unused code
    send_word(REQ_EVAL, 0, 0);
    send_word(REQ_ARC, 0, 1);                        // repeat -> multigraph
    send_word(REQ_EVAL, 0, 0);
    send_word(REQ_CLEAR, 0, 0);
    send_word(REQ_ARC, 0, 2);                        // 0,1 share 2 but differ
    send_word(REQ_ARC, 1, 2);
    send_word(REQ_ARC, 1, 3);
    send_word(REQ_EVAL, 0, 0);
    send_word(REQ_CLEAR, 0, 0);
    send_word(REQ_ARC, 2, 0);                        // shared predecessor
    send_word(REQ_ARC, 2, 1);
    send_word(REQ_ARC, 0, 3);
    send_word(REQ_ARC, 1, 3);
    send_word(REQ_EVAL, 0, 0);
    drain_and_config(6'd0);                          // zero used as one
    send_word(REQ_ARC, 0, 0);
    send_word(REQ_EVAL, 0, 0);
    drain_and_config(6'd63);                         // above max used as max
    send_word(REQ_ARC, 31, 31);
    send_word(REQ_EVAL, 0, 0);
  endtask

  // random builds: arcs between random used vertices, with occasional random codes
  task automatic test_random(input int items, input logic [5:0] vc);
    int n, k;
    drain_and_config(vc);
    n = used_vertices();
    k = 0;
    while (k < items) begin
      send_word(REQ_CLEAR, 5'($urandom), 5'($urandom));
      k++;
      repeat ($urandom_range(n + 2)) begin
        if ($urandom_range(9) == 0)
          send_word(2'($urandom_range(3)), 5'($urandom), 5'($urandom));
        else if ($urandom_range(2) == 0) begin
          // a random arc between any two used vertices
          send_word(REQ_ARC, 5'($urandom_range(n - 1)), 5'($urandom_range(n - 1)));
        end else
          send_word(REQ_ARC, 5'($urandom_range(n - 1) & 5'h1E), 5'($urandom_range(n - 1)));
        k++;
      end
      send_word(REQ_EVAL, 5'($urandom), 5'($urandom));
      k++;
    end
  endtask

  task automatic test_backpressure();
    hold_off_cycles = 800;
    for (int i = 0; i < 6; i++) send_word(REQ_EVAL, 0, 0);
    stop_sending();
    while (expected_words.size() != 0) @(negedge clk_i);  // sender pauses
    send_word(REQ_EVAL, 0, 0);
    stop_sending();
  endtask

  initial begin
    errors = 0;
    idle_cycles = 0;
    evals_seen = 0;
    hold_off_cycles = 0;
    vcnt_reg = VCNT_RESET;
    foreach (adj_rows[i]) adj_rows[i] = '0;
    multi_flag = 1'b0;
    send_idle_pct = 38;
    recv_idle_pct = 60;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random(150, 6'd3);
    send_idle_pct = 60;
    recv_idle_pct = 38;
    test_random(150, 6'd8);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(100, 6'd32);
    test_random(50, 6'd1);
    test_backpressure();
    while (expected_words.size() != 0) @(negedge clk_i);
    repeat (700) @(negedge clk_i);
    if (errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
